@@ hdl/spd_pkg.sv @@
// Package for the servo packet deframer: item and result types, protocol bytes, CRC step.
// Used by spd_front, spd_engine and servo_packet_deframer.
`timescale 1ns / 1ps
package spd_pkg;

	typedef enum logic [1:0] {
		K_BYTE = 2'd0,
		K_TICK = 2'd1,
		K_POP  = 2'd2,
		K_NONE = 2'd3
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic        packet_done;
		logic        packet_ready;
		logic [7:0]  packet_id;
		logic [7:0]  instruction;
		logic [7:0]  error_code;
		logic [7:0]  payload_count;
		logic [7:0]  read_data;
		logic        read_valid;
		logic        busy_res;
	} result_t;

	localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
	localparam logic [7:0]  HDR3_BYTE    = 8'hFD;
	localparam logic [7:0]  HDR4_BYTE    = 8'h00;
	localparam logic [7:0]  STATUS_INSTR = 8'h55;
	localparam logic [15:0] CRC_POLY     = 16'h8005;

	// One byte of CRC-16, MSB first
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	localparam logic [15:0] HDR_CRC =
		crc_step(crc_step(crc_step(crc_step(16'h0000, SYNC_BYTE), SYNC_BYTE), HDR3_BYTE),
			HDR4_BYTE);

endpackage

@@ hdl/spd_front.sv @@
// Front end: accepts requests, classifies the action, holds them in a two-entry queue.
// Depends on spd_pkg.
`timescale 1ns / 1ps
module spd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        action,
	input  logic [7:0]        data_byte,
	output logic              item_valid,
	output spd_pkg::item_t    item,
	input  logic              item_take
);
	import spd_pkg::*;

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       put;
	logic       take;
	item_kind_t kind;

	// Classify the action code
	always_comb begin
		unique case (action)
			2'd0: kind = K_BYTE;
			2'd1: kind = K_TICK;
			2'd2: kind = K_POP;
			default: kind = K_NONE;
		endcase
	end

	assign full       = (cnt_q == 2'd2);
	assign put        = push && !full;
	assign item_valid = (cnt_q != 2'd0);
	assign take       = item_take && item_valid;
	assign item       = slot_q[rd_q];

	// Store the request
	always_ff @(posedge clk) begin
		if (put) slot_q[wr_q] <= '{kind: kind, data: data_byte};
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (put) wr_q <= !wr_q;
			if (take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, put} - {1'b0, take};
		end
	end
endmodule

@@ hdl/spd_engine.sv @@
// Back end: frame parser, CRC check, payload store and result queue.
// Depends on spd_pkg.
`timescale 1ns / 1ps
module spd_engine #(
	parameter int MAX_LENGTH   = 250,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  spd_pkg::item_t    item,
	output logic              item_take,
	input  logic [7:0]        timeout_limit,
	input  logic              res_pop,
	output logic              res_empty,
	output spd_pkg::result_t  res
);
	import spd_pkg::*;

	localparam int IW = $clog2(BUFFER_DEPTH);
	localparam int LW = $clog2(MAX_LENGTH + 1);
	localparam int OD = 4;

	typedef enum logic [2:0] {
		ST_HUNT, ST_HDR2, ST_HDR3, ST_HDR4, ST_ID, ST_LENLO, ST_LENHI, ST_BODY
	} pstate_t;

	pstate_t     st_q, st_n, st_e;
	logic [7:0]  idle_q, idle_n;
	logic [15:0] crc_q, crc_n;
	logic [15:0] flen_q, flen_n;
	logic [LW-1:0] left_q, left_n;
	logic [7:0]  rcrc_q, rcrc_n;
	logic [7:0]  id_q, id_n;
	logic [7:0]  instr_q, instr_n;
	logic [7:0]  err_q, err_n;
	logic [7:0]  first_q, second_q;
	logic [IW-1:0] widx_q, widx_n;
	logic [IW-1:0] ridx_q, ridx_n;
	logic [LW-1:0] rleft_q, rleft_n;
	logic        rdy_q, rdy_n;
	logic        done;
	logic        wr_en;
	logic        rd_en;
	logic [7:0]  d;
	logic [15:0] rcv_full;
	logic [LW-1:0] bl_dec;
	logic [7:0]  acc_instr;
	logic [7:0]  acc_err;
	logic        go;

	logic [7:0]  mem [BUFFER_DEPTH];
	logic [7:0]  rdata_s2;
	result_t     res_s2;
	logic        v_s2;

	result_t     oq_q [OD];
	logic [1:0]  owr_q, ord_q;
	logic [2:0]  ocnt_q;
	logic        opop;
	result_t     res_in;

	// Issue only while the result queue has room for everything in flight
	assign go        = item_valid && ({1'b0, ocnt_q} + {3'b000, v_s2} <= 4'd2);
	assign item_take = go;
	assign d         = item.data;

	// Parser next state
	always_comb begin
		st_n    = st_q;
		idle_n  = idle_q;
		crc_n   = crc_q;
		flen_n  = flen_q;
		left_n  = left_q;
		rcrc_n  = rcrc_q;
		id_n    = id_q;
		instr_n = instr_q;
		err_n   = err_q;
		widx_n  = widx_q;
		ridx_n  = ridx_q;
		rleft_n = rleft_q;
		rdy_n   = rdy_q;
		done    = 1'b0;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		st_e    = (idle_q > timeout_limit) ? ST_HUNT : st_q;
		bl_dec  = (left_q != '0) ? left_q - LW'(1) : left_q;
		rcv_full = {d, rcrc_q};
		acc_instr = (widx_q == '0) ? d : first_q;
		acc_err   = (widx_q == IW'(1)) ? d : second_q;
		unique case (item.kind)
			K_BYTE: begin
				rdy_n  = 1'b0;
				idle_n = 8'd0;
				unique case (st_e)
					ST_HUNT: begin
						if (d == SYNC_BYTE) begin
							st_n = ST_HDR2; widx_n = '0; crc_n = 16'h0000;
						end else st_n = ST_HUNT;
					end
					ST_HDR2: st_n = (d == SYNC_BYTE) ? ST_HDR3 : ST_HUNT;
					ST_HDR3: begin
						if (d == HDR3_BYTE) st_n = ST_HDR4;
						else if (d == SYNC_BYTE) begin
							st_n = ST_HDR2; widx_n = '0; crc_n = 16'h0000;
						end else st_n = ST_HUNT;
					end
					ST_HDR4: begin
						if (d == HDR4_BYTE) begin
							crc_n = HDR_CRC; st_n = ST_ID;
						end else if (d == SYNC_BYTE) begin
							st_n = ST_HDR2; widx_n = '0; crc_n = 16'h0000;
						end else st_n = ST_HUNT;
					end
					ST_ID: begin
						if (d != SYNC_BYTE) begin
							id_n = d; crc_n = crc_step(crc_q, d); st_n = ST_LENLO;
						end else begin
							st_n = ST_HDR2; widx_n = '0; crc_n = 16'h0000;
						end
					end
					ST_LENLO: begin
						flen_n = {8'h00, d};
						crc_n  = crc_step(crc_q, d);
						st_n   = ST_LENHI;
					end
					ST_LENHI: begin
						flen_n = {d, flen_q[7:0]};
						if (flen_n == 16'd0 || flen_n > 16'(MAX_LENGTH)) st_n = ST_HUNT;
						else begin
							if (flen_n >= 16'd2) crc_n = crc_step(crc_q, d);
							left_n = flen_n[LW-1:0];
							rcrc_n = 8'h00;
							widx_n = '0;
							st_n   = ST_BODY;
						end
					end
					default: begin
						wr_en  = 1'b1;
						widx_n = (widx_q == IW'(BUFFER_DEPTH - 1)) ? '0 : widx_q + IW'(1);
						if (left_q > LW'(2)) crc_n = crc_step(crc_q, d);
						left_n = bl_dec;
						if (bl_dec == LW'(1)) rcrc_n = d;
						else if (bl_dec == '0) begin
							st_n = ST_HUNT;
							if (rcv_full == crc_q) begin
								done    = 1'b1;
								rdy_n   = 1'b1;
								instr_n = acc_instr;
								if (acc_instr == STATUS_INSTR) begin
									err_n   = (flen_q >= 16'd2) ? acc_err : 8'h00;
									ridx_n  = IW'(2);
									rleft_n = (flen_q > 16'd4) ? LW'(flen_q - 16'd4) : '0;
								end else begin
									err_n   = 8'h00;
									ridx_n  = IW'(1);
									rleft_n = (flen_q > 16'd3) ? LW'(flen_q - 16'd3) : '0;
								end
							end
						end
					end
				endcase
			end
			K_TICK: begin
				if (idle_q != 8'hFF) idle_n = idle_q + 8'd1;
			end
			K_POP: begin
				if (rleft_q != '0) begin
					rd_en   = 1'b1;
					ridx_n  = (ridx_q == IW'(BUFFER_DEPTH - 1)) ? '0 : ridx_q + IW'(1);
					rleft_n = rleft_q - LW'(1);
				end
			end
			default: ;
		endcase
	end

	// Hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_HUNT;
			idle_q  <= 8'd0;
			crc_q   <= 16'h0000;
			flen_q  <= 16'd0;
			left_q  <= '0;
			rcrc_q  <= 8'h00;
			id_q    <= 8'h00;
			instr_q <= 8'h00;
			err_q   <= 8'h00;
			widx_q  <= '0;
			ridx_q  <= '0;
			rleft_q <= '0;
			rdy_q   <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s2 <= go;
			if (go) begin
				st_q    <= st_n;
				idle_q  <= idle_n;
				crc_q   <= crc_n;
				flen_q  <= flen_n;
				left_q  <= left_n;
				rcrc_q  <= rcrc_n;
				id_q    <= id_n;
				instr_q <= instr_n;
				err_q   <= err_n;
				widx_q  <= widx_n;
				ridx_q  <= ridx_n;
				rleft_q <= rleft_n;
				rdy_q   <= rdy_n;
			end
		end
	end

	// Payload store, first two entries shadowed for the instruction and error bytes
	always_ff @(posedge clk) begin
		if (go && wr_en) begin
			mem[widx_q] <= d;
			if (widx_q == '0) first_q <= d;
			if (widx_q == IW'(1)) second_q <= d;
		end
		if (go && rd_en) rdata_s2 <= mem[ridx_q];
		if (go) begin
			res_s2.packet_done   <= done;
			res_s2.packet_ready  <= rdy_n;
			res_s2.packet_id     <= rdy_n ? id_n : 8'h00;
			res_s2.instruction   <= instr_n;
			res_s2.error_code    <= err_n;
			res_s2.payload_count <= (rdy_n && flen_n > 16'd3) ? 8'(flen_n - 16'd3) : 8'h00;
			res_s2.read_data     <= 8'h00;
			res_s2.read_valid    <= rd_en;
			res_s2.busy_res      <= (st_n != ST_HUNT);
		end
	end

	// Merge the read data into the result
	always_comb begin
		res_in = res_s2;
		res_in.read_data = res_s2.read_valid ? rdata_s2 : 8'h00;
	end

	// Result queue
	assign res_empty = (ocnt_q == 3'd0);
	assign opop      = res_pop && !res_empty;
	assign res       = oq_q[ord_q];

	always_ff @(posedge clk) begin
		if (v_s2) oq_q[owr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 2'd0;
			ord_q  <= 2'd0;
			ocnt_q <= 3'd0;
		end else begin
			if (v_s2) owr_q <= owr_q + 2'd1;
			if (opop) ord_q <= ord_q + 2'd1;
			ocnt_q <= ocnt_q + {2'b00, v_s2} - {2'b00, opop};
		end
	end
endmodule

@@ hdl/servo_packet_deframer.sv @@
// Servo packet deframer: input queue, parser and result register, then the result queue.
// One request per cycle (parser step and store port) while the result queue has room.
// Results wait in a four-entry queue; the input queue holds two requests.
// Reset (arst_n low) hunts for the header, clears control state, timeout limit 5.
// Top level; depends on spd_pkg, spd_front, spd_engine.
`timescale 1ns / 1ps
module servo_packet_deframer #(
	parameter int MAX_LENGTH   = 250,
	parameter int BUFFER_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	output logic       empty,
	input  logic       pop,
	output logic       packet_done,
	output logic       packet_ready,
	output logic [7:0] packet_id,
	output logic [7:0] instruction,
	output logic [7:0] error_code,
	output logic [7:0] payload_count,
	output logic [7:0] read_data,
	output logic       read_valid,
	output logic       busy_res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import spd_pkg::*;

	item_t      item;
	logic       item_valid;
	logic       item_take;
	result_t    res;
	logic [7:0] timeout_q;

	// Configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= 8'd5;
		else if (cfg_valid) timeout_q <= cfg_data;
	end

	spd_front u_front (
		.clk, .arst_n, .push, .full, .action, .data_byte,
		.item_valid, .item, .item_take
	);

	spd_engine #(.MAX_LENGTH(MAX_LENGTH), .BUFFER_DEPTH(BUFFER_DEPTH)) u_engine (
		.clk, .arst_n, .item_valid, .item, .item_take,
		.timeout_limit(timeout_q), .res_pop(pop), .res_empty(empty), .res
	);

	assign packet_done   = res.packet_done;
	assign packet_ready  = res.packet_ready;
	assign packet_id     = res.packet_id;
	assign instruction   = res.instruction;
	assign error_code    = res.error_code;
	assign payload_count = res.payload_count;
	assign read_data     = res.read_data;
	assign read_valid    = res.read_valid;
	assign busy_res      = res.busy_res;
endmodule

@@ tb/sv/spd_checker.sv @@
// Checker for the servo packet deframer: watches requests, results and the config channel,
// predicts each result in its own parser model and compares field by field. Depends on spd_pkg.
`timescale 1ns / 1ps
module spd_checker
	import spd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [1:0] action,
	input  logic [7:0] data_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic       packet_done,
	input  logic       packet_ready,
	input  logic [7:0] packet_id,
	input  logic [7:0] instruction,
	input  logic [7:0] error_code,
	input  logic [7:0] payload_count,
	input  logic [7:0] read_data,
	input  logic       read_valid,
	input  logic       busy_res,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         pending
);

	typedef enum logic [2:0] {
		P_HUNT, P_HDR2, P_HDR3, P_HDR4, P_ID, P_LENLO, P_LENHI, P_BODY
	} parse_t;

	parse_t      pstate;
	logic [7:0]  tmo_limit;
	logic [7:0]  idle_cnt;
	logic [15:0] crc_acc;
	logic [15:0] frame_len;
	logic [7:0]  body_left;
	logic [15:0] crc_rx;
	logic [7:0]  id_hold;
	logic [7:0]  instr_hold;
	logic [7:0]  err_hold;
	logic [7:0]  pay_mem [0:255];
	logic [7:0]  wr_ptr;
	logic [7:0]  rd_ptr;
	logic [7:0]  rd_left;
	logic        held;
	result_t     due_q[$];
	result_t     got;
	result_t     want;

	// CRC-16, poly 0x8005, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ 16'h8005) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic void restart_frame();
		pstate = P_HDR2;
		wr_ptr = 8'h00;
		crc_acc = 16'h0000;
	endfunction

	// Advance the parser by one received byte; return 1 on a good packet
	function automatic bit parse_byte(input logic [7:0] d);
		bit done;
		done = 0;
		held = 0;
		if (idle_cnt > tmo_limit) pstate = P_HUNT;
		idle_cnt = 8'd0;
		case (pstate)
			P_HUNT: if (d == SYNC_BYTE) restart_frame();
			P_HDR2: pstate = (d == SYNC_BYTE) ? P_HDR3 : P_HUNT;
			P_HDR3: begin
				if (d == HDR3_BYTE) pstate = P_HDR4;
				else if (d == SYNC_BYTE) restart_frame();
				else pstate = P_HUNT;
			end
			P_HDR4: begin
				if (d == HDR4_BYTE) begin
					crc_acc = crc_byte(crc_byte(crc_byte(crc_byte(16'h0, 8'hFF), 8'hFF),
						8'hFD), 8'h00);
					pstate = P_ID;
				end else if (d == SYNC_BYTE) restart_frame();
				else pstate = P_HUNT;
			end
			P_ID: begin
				if (d != 8'hFF) begin
					id_hold = d;
					crc_acc = crc_byte(crc_acc, d);
					pstate = P_LENLO;
				end else restart_frame();
			end
			P_LENLO: begin
				frame_len = {8'h00, d};
				crc_acc = crc_byte(crc_acc, d);
				pstate = P_LENHI;
			end
			P_LENHI: begin
				frame_len[15:8] = d;
				if (frame_len == 16'd0 || frame_len > 16'd250) pstate = P_HUNT;
				else begin
					if (frame_len >= 16'd2) crc_acc = crc_byte(crc_acc, d);
					body_left = frame_len[7:0];
					crc_rx = 16'h0000;
					wr_ptr = 8'h00;
					pstate = P_BODY;
				end
			end
			default: begin
				pay_mem[wr_ptr] = d;
				wr_ptr = wr_ptr + 8'd1;
				if (body_left > 8'd2) crc_acc = crc_byte(crc_acc, d);
				if (body_left > 8'd0) body_left = body_left - 8'd1;
				if (body_left == 8'd1) crc_rx = {8'h00, d};
				else if (body_left == 8'd0) begin
					crc_rx = {d, crc_rx[7:0]};
					pstate = P_HUNT;
					if (crc_rx == crc_acc) begin
						instr_hold = pay_mem[0];
						if (instr_hold == STATUS_INSTR) begin
							err_hold = (frame_len >= 16'd2) ? pay_mem[1] : 8'h00;
							rd_ptr = 8'd2;
							rd_left = (frame_len > 16'd4) ? 8'(frame_len - 16'd4) : 8'h00;
						end else begin
							err_hold = 8'h00;
							rd_ptr = 8'd1;
							rd_left = (frame_len > 16'd3) ? 8'(frame_len - 16'd3) : 8'h00;
						end
						held = 1;
						done = 1;
					end
				end
			end
		endcase
		return done;
	endfunction

	// Work out the result of one request
	function automatic result_t predict_result(input item_kind_t kind, input logic [7:0] d);
		result_t r;
		r = '0;
		case (kind)
			K_BYTE: r.packet_done = parse_byte(d);
			K_TICK: if (idle_cnt != 8'hFF) idle_cnt = idle_cnt + 8'd1;
			K_POP: begin
				if (rd_left > 8'd0) begin
					r.read_data = pay_mem[rd_ptr];
					r.read_valid = 1;
					rd_ptr = rd_ptr + 8'd1;
					rd_left = rd_left - 8'd1;
				end
			end
			default: ;
		endcase
		r.packet_ready = held;
		r.packet_id = held ? id_hold : 8'h00;
		r.instruction = instr_hold;
		r.error_code = err_hold;
		r.payload_count = (held && frame_len > 16'd3) ? 8'(frame_len - 16'd3) : 8'h00;
		r.busy_res = (pstate != P_HUNT);
		return r;
	endfunction

	task automatic report(input string field, input int g, input int w);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", field, g, w, $realtime);
		errors++;
	endtask

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate = P_HUNT;
			tmo_limit = 8'd5;
			idle_cnt = 0;
			crc_acc = 0;
			frame_len = 0;
			body_left = 0;
			crc_rx = 0;
			id_hold = 0;
			instr_hold = 0;
			err_hold = 0;
			wr_ptr = 0;
			rd_ptr = 0;
			rd_left = 0;
			held = 0;
			for (int i = 0; i < 256; i++) pay_mem[i] = 0;
			due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) tmo_limit = cfg_data;
			// compare the popped result against the oldest prediction
			if (pop && !empty) begin
				got = '{packet_done, packet_ready, packet_id, instruction, error_code,
					payload_count, read_data, read_valid, busy_res};
				if (due_q.size() == 0) begin
					$display("MISMATCH unexpected result at %0t", $realtime);
					errors++;
				end else begin
					want = due_q.pop_front();
					if (got.packet_done != want.packet_done)
						report("packet_done", got.packet_done, want.packet_done);
					if (got.packet_ready != want.packet_ready)
						report("packet_ready", got.packet_ready, want.packet_ready);
					if (got.packet_id != want.packet_id)
						report("packet_id", got.packet_id, want.packet_id);
					if (got.instruction != want.instruction)
						report("instruction", got.instruction, want.instruction);
					if (got.error_code != want.error_code)
						report("error_code", got.error_code, want.error_code);
					if (got.payload_count != want.payload_count)
						report("payload_count", got.payload_count, want.payload_count);
					if (got.read_data != want.read_data)
						report("read_data", got.read_data, want.read_data);
					if (got.read_valid != want.read_valid)
						report("read_valid", got.read_valid, want.read_valid);
					if (got.busy_res != want.busy_res)
						report("busy_res", got.busy_res, want.busy_res);
				end
			end
			if (push && !full) due_q.push_back(predict_result(item_kind_t'(action), data_byte));
		end
		pending = due_q.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for servo_packet_deframer: clock, reset, request and pop stimulus, config
// phases and verdict. Depends on spd_pkg, servo_packet_deframer and spd_checker.
`timescale 1ns / 1ps
module tb_top;
	import spd_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic       empty;
	logic       pop;
	logic       packet_done;
	logic       packet_ready;
	logic [7:0] packet_id;
	logic [7:0] instruction;
	logic [7:0] error_code;
	logic [7:0] payload_count;
	logic [7:0] read_data;
	logic       read_valid;
	logic       busy_res;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	int         errors;
	int         pending;
	int         sent;
	int         quiet;
	bit         calm;
	logic [7:0] cur_limit;

	servo_packet_deframer u_top (.*);

	spd_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Pop side: random stalls, none during the calm stretch
	always @(negedge clk) pop <= calm || ($urandom_range(99) >= 32);

	// Drive one request and hold it until accepted
	task automatic put_item(input item_kind_t k, input logic [7:0] d);
		int gap;
		gap = (!calm && $urandom_range(99) < 32) ? $urandom_range(1, 3) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(negedge clk);
		end
		push <= 1;
		action <= k;
		data_byte <= d;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
		calm = (sent >= 320 && sent < 460);
	endtask

	// Occasional ticks, pops or dead requests between frame bytes
	task automatic filler();
		int r;
		int n;
		r = $urandom_range(99);
		n = (cur_limit < 6) ? $urandom_range(0, cur_limit + 1) : $urandom_range(0, 3);
		if (r < 10) repeat (n) put_item(K_TICK, 8'($urandom_range(255)));
		else if (r < 17) put_item(K_POP, 8'($urandom_range(255)));
		else if (r < 19) put_item(K_NONE, 8'($urandom_range(255)));
	endtask

	// Build and send a frame; bad lengths send up to three random bytes after the length field
	task automatic send_frame(input int len, input bit bad_crc, input bit status);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		logic [7:0]  instr;
		int          hstart;
		int          k;
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(3);
			fb.push_back(k == 0 ? 8'hFF : k == 1 ? 8'hFD : k == 2 ? 8'h00 : 8'($urandom));
		end
		hstart = fb.size();
		fb.push_back(SYNC_BYTE);
		fb.push_back(SYNC_BYTE);
		fb.push_back(HDR3_BYTE);
		fb.push_back(HDR4_BYTE);
		// an id of FF falls back to the second header byte: resend the rest of the header
		if ($urandom_range(19) == 0) begin
			fb.push_back(8'hFF);
			fb.push_back(SYNC_BYTE);
			fb.push_back(HDR3_BYTE);
			fb.push_back(HDR4_BYTE);
			hstart = fb.size() - 4;
		end
		fb.push_back(8'($urandom_range(254)));
		fb.push_back(8'(len));
		fb.push_back(8'(len >> 8));
		if (len == 0 || len > 250) begin
			repeat ($urandom_range(0, 3)) fb.push_back(8'($urandom_range(255)));
		end else begin
			instr = (status || $urandom_range(99) < 40) ? STATUS_INSTR :
				8'($urandom_range(255));
			for (int i = 0; i < len - 2; i++)
				fb.push_back(i == 0 ? instr : 8'($urandom));
			crc = 0;
			for (int i = hstart; i < fb.size(); i++)
				if (i != hstart + 6 || len >= 2) crc = crc_step(crc, fb[i]);
			if (len >= 2) fb.push_back(crc[7:0]);
			fb.push_back(crc[15:8]);
		end
		if (bad_crc) begin
			k = $urandom_range(hstart + 4, fb.size() - 1);
			fb[k][$urandom_range(7)] ^= 1'b1;
		end
		for (int i = 0; i < fb.size(); i++) begin
			put_item(K_BYTE, fb[i]);
			if (i < fb.size() - 1) filler();
		end
	endtask

	task automatic drain_pops(input int n);
		repeat (n) put_item(K_POP, 8'($urandom_range(255)));
	endtask

	// Hold off until every result is back, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		cur_limit = v;
	endtask

	// Stall watchdog
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("servo_packet_deframer verification failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] limits [4];
		int         len;
		int         r;
		arst_n = 0;
		push = 0;
		pop = 0;
		action = K_NONE;
		data_byte = 0;
		cfg_valid = 0;
		cfg_data = 0;
		sent = 0;
		calm = 0;
		cur_limit = 8'd5;
		limits[0] = 8'd0;
		limits[1] = 8'd255;
		limits[2] = 8'($urandom_range(1, 254));
		limits[3] = 8'd2;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty pop, dead request, tick, stray bytes, a short packet and a status packet
		put_item(K_POP, 8'hFF);
		put_item(K_NONE, 8'hFF);
		put_item(K_TICK, 8'h00);
		put_item(K_BYTE, 8'h00);
		put_item(K_BYTE, 8'hFF);
		put_item(K_BYTE, 8'h00);
		send_frame(3, 0, 0);
		drain_pops(1);
		send_frame(5, 0, 1);
		drain_pops(2);

		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_limit(limits[ph]);
			// long run of ticks: no timeout can happen at the top limit
			if (limits[ph] == 8'hFF) begin
				put_item(K_BYTE, 8'hFF);
				repeat (300) put_item(K_TICK, 8'h00);
			end
			while (sent < 30 + (ph + 1) * 190) begin
				r = $urandom_range(99);
				len = (r < 3) ? $urandom_range(17, 250) : $urandom_range(1, 16);
				if (r < 70) begin
					send_frame(len, 0, 0);
					drain_pops($urandom_range(0, len));
				end else if (r < 78) begin
					send_frame(len, 1, 0);
				end else if (r < 84) begin
					r = $urandom_range(2);
					send_frame(r == 0 ? 0 : r == 1 ? 251 : $urandom_range(252, 65535), 0, 0);
				end else if (r < 92) begin
					repeat ($urandom_range(1, 5)) put_item(K_BYTE, 8'($urandom_range(255)));
				end else begin
					repeat ($urandom_range(1, 6))
						put_item(item_kind_t'($urandom_range(1, 3)), 8'($urandom_range(255)));
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("servo_packet_deframer verification clean");
		else
			$display("servo_packet_deframer verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/spd_pkg.sv
hdl/spd_front.sv
hdl/spd_engine.sv
hdl/servo_packet_deframer.sv
tb/sv/spd_checker.sv
tb/sv/tb_top.sv
